FILE: hw/rtl/swrm_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window rate meter: shared types and constants
// Field widths, register codes, sequencer states and divider handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swrm_pkg;

  localparam int BYTE_W     = 32;
  localparam int TIME_W     = 48;
  localparam int PERIOD_W   = 16;
  localparam int SLOTS_W    = 7;
  localparam int BANK_W     = 40;
  localparam int SPEED_W    = 40;
  localparam int INT_W      = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_CNT_W  = 6;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd100;
  localparam logic [SLOTS_W-1:0]  SLOTS_RST  = 7'd10;

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD = 1'b0,
    REG_SLOTS  = 1'b1
  } cfg_reg_e;

  typedef enum logic [4:0] {
    S_SWEEP,
    S_IDLE,
    S_NMUL,
    S_NGO,
    S_NWAIT,
    S_FILL,
    S_PCHK,
    S_SMUL,
    S_SGO,
    S_SWAIT,
    S_PUT,
    S_SPD,
    S_KRD,
    S_SUM,
    S_XMK,
    S_VGO,
    S_VWAIT,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    SC_FIN,
    SC_NEWP,
    SC_KEEP
  } sc_kind_e;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
  } div_ctl_t;

  typedef struct packed {
    logic done;
    logic sat;
  } div_sts_t;

endpackage

FILE: hw/rtl/sliding_window_rate_meter_top.sv
// ----------------------------------------------------------------------------
// Sliding window rate meter
// Each beat is processed by a sequencer built around the shared
// one-bit-per-cycle divider; a clear sweeps the slot memory and then
// returns a zero speed.
// One beat in flight at a time; the result register frees input.
// Reset sweeps the slot memory with input stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_window_rate_meter_top #(
  parameter int MAX_SLOTS = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [swrm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [swrm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                action_i,
  input  logic [swrm_pkg::BYTE_W-1:0]         byte_count_i,
  input  logic [swrm_pkg::TIME_W-1:0]         time_ms_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [swrm_pkg::SPEED_W-1:0]        speed_per_second_o,
  output logic                                time_error_o
);

  localparam int VW  = swrm_pkg::INT_W + FRAC_BITS;
  localparam int NW  = $clog2(MAX_SLOTS + 1);
  localparam int AW  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW  = (NW > swrm_pkg::SLOTS_W) ? NW : swrm_pkg::SLOTS_W;
  localparam int PNW = swrm_pkg::PERIOD_W + NW;
  localparam int DW  = PNW + FRAC_BITS;
  localparam int RW  = (DW > swrm_pkg::TIME_W) ? DW : swrm_pkg::TIME_W;
  localparam int MA  = (VW > swrm_pkg::BANK_W + 1) ? VW : swrm_pkg::BANK_W + 1;
  localparam int PW  = MA + swrm_pkg::PERIOD_W;
  localparam int SW  = VW + NW + 1;
  localparam int XW  = SW + 10;
  localparam int LW  = VW;
  localparam int BW  = swrm_pkg::BANK_W;
  localparam int TW  = swrm_pkg::TIME_W;
  localparam int PRW = swrm_pkg::PERIOD_W;

  // configuration
  logic [PRW-1:0]                  period_q;
  logic [swrm_pkg::SLOTS_W-1:0]    slots_q;

  // tracking state
  swrm_pkg::state_e                state_q, state_d;
  logic [AW-1:0]                   next_q, next_d;
  logic [VW-1:0]                   pa_q, pa_d;
  logic [PRW-1:0]                  pt_q, pt_d;
  logic [BW-1:0]                   bank_q, bank_d;
  logic [TW-1:0]                   last_time_q, last_time_d;
  logic                            have_q, have_d;
  logic                            clr_item_q, clr_item_d;
  logic [NW-1:0]                   idx_q, idx_d;
  logic                            pend_q, pend_d;
  logic [AW-1:0]                   pidx_q, pidx_d;
  logic                            out_valid_q, out_valid_d;

  // work registers
  logic [BW:0]                     value_q, value_d;
  logic [TW-1:0]                   iv_q, iv_d;
  logic                            full_q, full_d;
  logic [VW-1:0]                   amt_q, amt_d;
  logic [VW-1:0]                   sc_v_q, sc_v_d;
  logic [PRW-1:0]                  part_q, part_d;
  logic [PRW-1:0]                  need_q, need_d;
  logic                            fin_lt_q, fin_lt_d;
  swrm_pkg::sc_kind_e              kind_q, kind_d;
  logic [PW-1:0]                   prod_q, prod_d;
  logic [SW-1:0]                   sum_q, sum_d;
  logic [XW-1:0]                   x_q, x_d;
  logic [VW:0]                     repl_q, repl_d;
  logic                            err_q, err_d;
  logic [swrm_pkg::SPEED_W-1:0]    speed_q, speed_d;
  logic [swrm_pkg::SPEED_W-1:0]    out_speed_q;
  logic                            out_err_q;

  // slot memory
  logic [VW-1:0]                   mem [MAX_SLOTS];
  logic [VW-1:0]                   mem_rdata_q;
  logic                            mem_we;
  logic [AW-1:0]                   mem_waddr;
  logic [VW-1:0]                   mem_wdata;
  logic                            mem_re;
  logic [AW-1:0]                   mem_raddr;

  // divider
  swrm_pkg::div_ctl_t              div_ctl;
  swrm_pkg::div_sts_t              div_sts;
  logic [RW-1:0]                   div_hi;
  logic [LW-1:0]                   div_lo;
  logic [RW-1:0]                   div_dvs;
  logic [LW-1:0]                   div_quot;

  // derived values
  logic [PRW-1:0]                  p_eff;
  logic [NW-1:0]                   n_eff;
  logic [CW-1:0]                   slots_ext;
  logic [PNW-1:0]                  pn;
  logic [DW-1:0]                   dspd;
  logic                            in_acc;
  logic                            out_load;
  logic [TW-1:0]                   iv_now;
  logic [BW:0]                     bank_sum;
  logic [AW-1:0]                   nxt_fix;
  logic [NW-1:0]                   nxt_p1;
  logic [AW-1:0]                   nxt_inc;
  logic [PRW-1:0]                  pt_need;
  logic [VW:0]                     pa_sum;
  logic [VW-1:0]                   pa_sat;
  logic [MA-1:0]                   mul_a;
  logic [PRW-1:0]                  mul_b;
  logic [VW:0]                     addend;

  assign p_eff     = (period_q == '0) ? PRW'(1) : period_q;
  assign slots_ext = CW'(slots_q);
  always_comb begin
    if (slots_q == '0) begin
      n_eff = NW'(1);
    end else if (slots_ext > CW'(MAX_SLOTS)) begin
      n_eff = NW'(MAX_SLOTS);
    end else begin
      n_eff = NW'(slots_ext);
    end
  end

  assign pn       = PNW'(p_eff) * PNW'(n_eff);
  assign dspd     = DW'(pn) << FRAC_BITS;
  assign in_stall_o = (state_q != swrm_pkg::S_IDLE);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_load = (state_q == swrm_pkg::S_OUT) && (!out_valid_q || !out_stall_i);
  assign iv_now   = time_ms_i - last_time_q;
  assign bank_sum = {1'b0, bank_q} + (BW + 1)'(byte_count_i);
  assign nxt_fix  = (NW'(next_q) >= n_eff) ? '0 : next_q;
  assign nxt_p1   = NW'(next_q) + NW'(1);
  assign nxt_inc  = (nxt_p1 >= n_eff) ? '0 : nxt_p1[AW-1:0];
  assign pt_need  = (pt_q >= p_eff) ? '0 : p_eff - pt_q;
  assign pa_sum   = {1'b0, pa_q} + {1'b0, div_quot};
  assign pa_sat   = pa_sum[VW] ? '1 : pa_sum[VW-1:0];
  assign addend   = ((pt_q != '0) && (pidx_q == next_q)) ? repl_q : {1'b0, mem_rdata_q};

  // shared multiplier operands
  always_comb begin
    if (state_q == swrm_pkg::S_NMUL) begin
      mul_a = MA'(value_q);
      mul_b = p_eff;
    end else begin
      mul_a = MA'(sc_v_q);
      mul_b = part_q;
    end
  end

  // divider operands
  always_comb begin
    div_ctl.start = 1'b0;
    div_ctl.steps = swrm_pkg::DIV_CNT_W'(VW);
    div_hi        = RW'(prod_q >> swrm_pkg::INT_W);
    div_lo        = LW'(prod_q[swrm_pkg::INT_W-1:0]) << FRAC_BITS;
    div_dvs       = RW'(iv_q);
    case (state_q)
      swrm_pkg::S_NGO: begin
        div_ctl.start = 1'b1;
      end
      swrm_pkg::S_SGO: begin
        div_ctl.start = 1'b1;
        div_hi        = RW'(prod_q >> VW);
        div_lo        = prod_q[VW-1:0];
        div_dvs       = RW'(p_eff);
      end
      swrm_pkg::S_VGO: begin
        div_ctl.start = 1'b1;
        div_ctl.steps = swrm_pkg::DIV_CNT_W'(swrm_pkg::SPEED_W);
        div_hi        = RW'(x_q >> swrm_pkg::SPEED_W);
        div_lo        = LW'(x_q[swrm_pkg::SPEED_W-1:0]) << (LW - swrm_pkg::SPEED_W);
        div_dvs       = RW'(dspd);
      end
      default: begin
      end
    endcase
  end

  swrm_div #(
    .RW(RW),
    .LW(LW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl),
    .hi_i   (div_hi),
    .lo_i   (div_lo),
    .dvs_i  (div_dvs),
    .quot_o (div_quot),
    .sts_o  (div_sts)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    next_d      = next_q;
    pa_d        = pa_q;
    pt_d        = pt_q;
    bank_d      = bank_q;
    last_time_d = last_time_q;
    have_d      = have_q;
    clr_item_d  = clr_item_q;
    idx_d       = idx_q;
    pend_d      = pend_q;
    pidx_d      = pidx_q;
    value_d     = value_q;
    iv_d        = iv_q;
    full_d      = full_q;
    amt_d       = amt_q;
    sc_v_d      = sc_v_q;
    part_d      = part_q;
    need_d      = need_q;
    fin_lt_d    = fin_lt_q;
    kind_d      = kind_q;
    prod_d      = prod_q;
    sum_d       = sum_q;
    x_d         = x_q;
    repl_d      = repl_q;
    err_d       = err_q;
    speed_d     = speed_q;
    mem_we      = 1'b0;
    mem_waddr   = next_q;
    mem_wdata   = amt_q;
    mem_re      = 1'b0;
    mem_raddr   = next_q;

    case (state_q)
      swrm_pkg::S_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q[AW-1:0];
        mem_wdata = '0;
        if (idx_q == NW'(MAX_SLOTS - 1)) begin
          idx_d = '0;
          if (clr_item_q) begin
            clr_item_d = 1'b0;
            speed_d    = '0;
            state_d    = swrm_pkg::S_OUT;
          end else begin
            state_d = swrm_pkg::S_IDLE;
          end
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      swrm_pkg::S_IDLE: begin
        if (in_acc) begin
          next_d = nxt_fix;
          err_d  = 1'b0;
          if (action_i == swrm_pkg::ACT_CLEAR) begin
            next_d      = '0;
            pa_d        = '0;
            pt_d        = '0;
            bank_d      = '0;
            last_time_d = '0;
            have_d      = 1'b0;
            idx_d       = '0;
            clr_item_d  = 1'b1;
            state_d     = swrm_pkg::S_SWEEP;
          end else if (!have_q) begin
            last_time_d = time_ms_i;
            have_d      = 1'b1;
            state_d     = swrm_pkg::S_SPD;
          end else if (time_ms_i < last_time_q) begin
            err_d   = 1'b1;
            state_d = swrm_pkg::S_SPD;
          end else begin
            last_time_d = time_ms_i;
            iv_d        = iv_now;
            if (iv_now == '0) begin
              // bank the bytes for the next beat
              bank_d  = bank_sum[BW] ? '1 : bank_sum[BW-1:0];
              state_d = swrm_pkg::S_SPD;
            end else if (iv_now >= TW'(pn)) begin
              full_d  = 1'b1;
              next_d  = '0;
              pa_d    = '0;
              pt_d    = '0;
              bank_d  = '0;
              value_d = (BW + 1)'(byte_count_i);
              state_d = swrm_pkg::S_NMUL;
            end else begin
              full_d  = 1'b0;
              bank_d  = '0;
              value_d = bank_sum;
              state_d = swrm_pkg::S_NMUL;
            end
          end
        end
      end

      swrm_pkg::S_NMUL: begin
        prod_d  = PW'(mul_a) * PW'(mul_b);
        state_d = swrm_pkg::S_NGO;
      end

      swrm_pkg::S_NGO: begin
        state_d = swrm_pkg::S_NWAIT;
      end

      swrm_pkg::S_NWAIT: begin
        if (div_sts.done) begin
          amt_d = div_sts.sat ? '1 : div_quot;
          if (full_q) begin
            idx_d   = '0;
            state_d = swrm_pkg::S_FILL;
          end else begin
            state_d = swrm_pkg::S_PCHK;
          end
        end
      end

      swrm_pkg::S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = idx_q[AW-1:0];
        mem_wdata = amt_q;
        if (idx_q == n_eff - NW'(1)) begin
          state_d = swrm_pkg::S_SPD;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      swrm_pkg::S_PCHK: begin
        // finalize the pending partial slot unless it holds nothing
        if ((pt_q != '0) && (pa_q != '0)) begin
          need_d   = pt_need;
          fin_lt_d = (iv_q < TW'(pt_need));
          part_d   = (iv_q < TW'(pt_need)) ? iv_q[PRW-1:0] : pt_need;
          sc_v_d   = amt_q;
          kind_d   = swrm_pkg::SC_FIN;
          state_d  = swrm_pkg::S_SMUL;
        end else begin
          state_d = swrm_pkg::S_PUT;
        end
      end

      swrm_pkg::S_SMUL: begin
        prod_d  = PW'(mul_a) * PW'(mul_b);
        state_d = swrm_pkg::S_SGO;
      end

      swrm_pkg::S_SGO: begin
        state_d = swrm_pkg::S_SWAIT;
      end

      swrm_pkg::S_SWAIT: begin
        if (div_sts.done) begin
          case (kind_q)
            swrm_pkg::SC_FIN: begin
              if (fin_lt_q) begin
                pt_d = pt_q + iv_q[PRW-1:0];
                pa_d = pa_sat;
                iv_d = '0;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = next_q;
                mem_wdata = pa_sat;
                next_d    = nxt_inc;
                iv_d      = iv_q - TW'(need_q);
                pa_d      = '0;
                pt_d      = '0;
              end
              state_d = swrm_pkg::S_PUT;
            end
            swrm_pkg::SC_NEWP: begin
              pa_d    = div_quot;
              state_d = swrm_pkg::S_SPD;
            end
            swrm_pkg::SC_KEEP: begin
              repl_d  = {1'b0, pa_q} + {1'b0, div_quot};
              sum_d   = '0;
              idx_d   = '0;
              pend_d  = 1'b0;
              state_d = swrm_pkg::S_SUM;
            end
            default: begin
              state_d = swrm_pkg::S_SPD;
            end
          endcase
        end
      end

      swrm_pkg::S_PUT: begin
        if (iv_q >= TW'(p_eff)) begin
          mem_we    = 1'b1;
          mem_waddr = next_q;
          mem_wdata = amt_q;
          next_d    = nxt_inc;
          iv_d      = iv_q - TW'(p_eff);
        end else if (iv_q != '0) begin
          // start a new partial slot with the remainder
          pt_d    = iv_q[PRW-1:0];
          sc_v_d  = amt_q;
          part_d  = iv_q[PRW-1:0];
          kind_d  = swrm_pkg::SC_NEWP;
          state_d = swrm_pkg::S_SMUL;
        end else begin
          state_d = swrm_pkg::S_SPD;
        end
      end

      swrm_pkg::S_SPD: begin
        sum_d  = '0;
        idx_d  = '0;
        pend_d = 1'b0;
        if (pt_q != '0) begin
          mem_re    = 1'b1;
          mem_raddr = next_q;
          state_d   = swrm_pkg::S_KRD;
        end else begin
          state_d = swrm_pkg::S_SUM;
        end
      end

      swrm_pkg::S_KRD: begin
        sc_v_d  = mem_rdata_q;
        part_d  = pt_need;
        kind_d  = swrm_pkg::SC_KEEP;
        state_d = swrm_pkg::S_SMUL;
      end

      swrm_pkg::S_SUM: begin
        // issue one read a cycle, add the data of the previous read
        pend_d = (idx_q < n_eff);
        pidx_d = idx_q[AW-1:0];
        if (idx_q < n_eff) begin
          mem_re    = 1'b1;
          mem_raddr = idx_q[AW-1:0];
          idx_d     = idx_q + 1'b1;
        end
        if (pend_q) begin
          sum_d = sum_q + SW'(addend);
        end
        if (!(idx_q < n_eff) && !pend_q) begin
          state_d = swrm_pkg::S_XMK;
        end
      end

      swrm_pkg::S_XMK: begin
        // times 1000 as 1024 - 16 - 8
        x_d     = (XW'(sum_q) << 10) - (XW'(sum_q) << 4) - (XW'(sum_q) << 3);
        state_d = swrm_pkg::S_VGO;
      end

      swrm_pkg::S_VGO: begin
        state_d = swrm_pkg::S_VWAIT;
      end

      swrm_pkg::S_VWAIT: begin
        if (div_sts.done) begin
          speed_d = div_sts.sat ? '1 : div_quot[swrm_pkg::SPEED_W-1:0];
          state_d = swrm_pkg::S_OUT;
        end
      end

      swrm_pkg::S_OUT: begin
        if (out_load) begin
          state_d = swrm_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = swrm_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= swrm_pkg::PERIOD_RST;
      slots_q  <= swrm_pkg::SLOTS_RST;
    end else if (cfg_we_i) begin
      case (swrm_pkg::cfg_reg_e'(cfg_idx_i))
        swrm_pkg::REG_PERIOD: period_q <= cfg_data_i;
        swrm_pkg::REG_SLOTS:  slots_q  <= cfg_data_i[swrm_pkg::SLOTS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swrm_pkg::S_SWEEP;
      next_q      <= '0;
      pa_q        <= '0;
      pt_q        <= '0;
      bank_q      <= '0;
      last_time_q <= '0;
      have_q      <= 1'b0;
      clr_item_q  <= 1'b0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_q      <= next_d;
      pa_q        <= pa_d;
      pt_q        <= pt_d;
      bank_q      <= bank_d;
      last_time_q <= last_time_d;
      have_q      <= have_d;
      clr_item_q  <= clr_item_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q   <= pidx_d;
    value_q  <= value_d;
    iv_q     <= iv_d;
    full_q   <= full_d;
    amt_q    <= amt_d;
    sc_v_q   <= sc_v_d;
    part_q   <= part_d;
    need_q   <= need_d;
    fin_lt_q <= fin_lt_d;
    kind_q   <= kind_d;
    prod_q   <= prod_d;
    sum_q    <= sum_d;
    x_q      <= x_d;
    repl_q   <= repl_d;
    err_q    <= err_d;
    speed_q  <= speed_d;
    if (out_load) begin
      out_speed_q <= speed_q;
      out_err_q   <= err_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      mem_rdata_q <= mem[mem_raddr];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign speed_per_second_o = out_speed_q;
  assign time_error_o       = out_err_q;

endmodule

FILE: hw/rtl/swrm_div.sv
// ----------------------------------------------------------------------------
// Sliding window rate meter: restoring divider
// One quotient bit per cycle. Flags saturation when the high part of the
// dividend is not below the divisor, so the quotient would not fit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swrm_div #(
  parameter int RW = 48,
  parameter int LW = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  swrm_pkg::div_ctl_t   ctl_i,
  input  logic [RW-1:0]        hi_i,
  input  logic [LW-1:0]        lo_i,
  input  logic [RW-1:0]        dvs_i,
  output logic [LW-1:0]        quot_o,
  output swrm_pkg::div_sts_t   sts_o
);

  logic                           run_q;
  logic [swrm_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                           done_q;
  logic                           sat_q;
  logic [RW-1:0]                  r_q;
  logic [RW-1:0]                  d_q;
  logic [LW-1:0]                  l_q;
  logic [LW-1:0]                  q_q;
  logic [RW:0]                    r2;
  logic [RW:0]                    diff;
  logic                           ge;

  assign r2   = {r_q, l_q[LW-1]};
  assign diff = r2 - {1'b0, d_q};
  assign ge   = (r2 >= {1'b0, d_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
      sat_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        if (hi_i >= dvs_i) begin
          sat_q  <= 1'b1;
          done_q <= 1'b1;
          run_q  <= 1'b0;
        end else begin
          sat_q <= 1'b0;
          run_q <= 1'b1;
          cnt_q <= ctl_i.steps;
        end
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == swrm_pkg::DIV_CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      r_q <= hi_i;
      l_q <= lo_i;
      d_q <= dvs_i;
      q_q <= '0;
    end else if (run_q) begin
      r_q <= ge ? diff[RW-1:0] : r2[RW-1:0];
      l_q <= l_q << 1;
      q_q <= {q_q[LW-2:0], ge};
    end
  end

  assign quot_o     = q_q;
  assign sts_o.done = done_q;
  assign sts_o.sat  = sat_q;

endmodule
